// File: rtl/core/srlm_pkg.sv
package srlm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 43;
    localparam int CNT_W       = 13;
    localparam int DECAY_W     = 17;
    localparam int MAX_FRAMES  = 4096;
    localparam int MEAN_W      = 31;
    localparam int ROOT_W      = 32;
    localparam int PROD_W      = 34;
    localparam int STEP_W      = 6;
    localparam int DIV_STEPS   = SUM_W;
    localparam int SQRT_STEPS  = 16;

    localparam logic [DECAY_W-1:0]  DECAY_RESET = 17'd55706;
    localparam logic [DECAY_W-1:0]  ONE_Q16     = 17'd65536;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 16'd32768;
    localparam logic [ROOT_W-1:0]   SQRT_BIT0   = 32'h4000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } srlm_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] rms;
        logic [CNT_W-1:0]    frames_counted;
        logic                overlong;
    } srlm_out_t;

    // one finished buffer, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             overlong;
    } srlm_buf_t;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } srlm_q_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_MUL_A,
        BK_MUL_B,
        BK_DONE
    } srlm_back_state_t;

endpackage

// File: rtl/core/srlm_front.sv
module srlm_front
    import srlm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  srlm_in_t  s_data,
    input  logic      q_full,
    output logic      q_push,
    output srlm_buf_t q_data
);

    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [SAMPLE_W:0]   pair_sum;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] mag;
    logic [2*SAMPLE_W-1:0] square;
    logic                in_range;
    logic                accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // mid = floor((l + r) / 2); magnitude of 0x8000 still fits unsigned
    assign pair_sum = {s_data.left[SAMPLE_W-1], s_data.left}
                    + {s_data.right[SAMPLE_W-1], s_data.right};
    assign mid      = pair_sum[SAMPLE_W:1];
    assign mag      = mid[SAMPLE_W-1] ? (SAMPLE_W'(0) - mid) : mid;
    assign square   = mag * mag;
    assign in_range = count_reg < CNT_W'(MAX_FRAMES);

    always_comb begin
        if (in_range) begin
            sum_next   = sum_reg + SUM_W'(square);
            count_next = count_reg + CNT_W'(1);
            ovf_next   = ovf_reg;
        end else begin
            sum_next   = sum_reg;
            count_next = count_reg;
            ovf_next   = 1'b1;
        end
    end

    assign q_push         = accept && s_data.last;
    assign q_data.sum      = sum_next;
    assign q_data.count    = count_next;
    assign q_data.overlong = ovf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept) begin
            if (s_data.last) begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// File: rtl/core/srlm_queue.sv
module srlm_queue
    import srlm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  srlm_buf_t   wr_data,
    input  logic        pop,
    output srlm_buf_t   rd_data,
    output logic        full,
    output logic        empty
);

    srlm_buf_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full    = fill_reg == 2'd2;
    assign empty   = fill_reg == 2'd0;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/srlm_back.sv
module srlm_back
    import srlm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  srlm_buf_t          q_data,
    output logic               q_pop,
    input  logic [DECAY_W-1:0] decay,
    output logic               m_valid,
    input  logic               m_ready,
    output srlm_out_t          m_data
);

    srlm_back_state_t state_reg, state_next;

    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W:0]      div_trial;
    logic [STEP_W-1:0]   step_reg;
    logic                ovf_reg;
    logic [ROOT_W-1:0]   x_reg, x_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W-1:0]   bit_reg;
    logic [ROOT_W-1:0]   sqrt_trial;
    logic [SAMPLE_W-1:0] rms_reg;
    logic [SAMPLE_W-1:0] level_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DECAY_W-1:0]  d_eff;
    logic [DECAY_W-1:0]  w_new;
    logic [PROD_W-1-16:0] lv_raw;
    logic [SAMPLE_W-1:0] lv_clamped;
    logic                out_free;
    logic                load_out;
    logic                m_valid_reg;
    srlm_out_t           m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (!q_empty) state_next = BK_DIV;
            BK_DIV:   if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = BK_SQRT;
            BK_SQRT:  if (step_reg == STEP_W'(SQRT_STEPS - 1)) state_next = BK_MUL_A;
            BK_MUL_A: state_next = BK_MUL_B;
            BK_MUL_B: state_next = BK_DONE;
            BK_DONE:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop    = !q_empty;
            BK_DONE: load_out = out_free;
            default: begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // restoring divide, one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    always_comb begin
        if (div_trial >= {1'b0, div_reg}) begin
            rem_next = CNT_W'(div_trial - {1'b0, div_reg});
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_next = div_trial[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    // digit-by-digit square root, two radicand bits per cycle
    assign sqrt_trial = root_reg + bit_reg;
    always_comb begin
        if (x_reg >= sqrt_trial) begin
            x_next    = x_reg - sqrt_trial;
            root_next = (root_reg >> 1) + bit_reg;
        end else begin
            x_next    = x_reg;
            root_next = root_reg >> 1;
        end
    end

    assign d_eff      = (decay > ONE_Q16) ? ONE_Q16 : decay;
    assign w_new      = ONE_Q16 - d_eff;
    assign lv_raw     = prod_reg[PROD_W-1:16];
    assign lv_clamped = (lv_raw > (PROD_W-16)'(FULL_SCALE)) ? FULL_SCALE
                                                            : lv_raw[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                rem_reg  <= '0;
                quo_reg  <= q_data.sum;
                div_reg  <= q_data.count;
                ovf_reg  <= q_data.overlong;
                step_reg <= '0;
            end
            BK_DIV: begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    step_reg <= '0;
                    x_reg    <= ROOT_W'(quo_next[MEAN_W-1:0]);
                    root_reg <= '0;
                    bit_reg  <= SQRT_BIT0;
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
            BK_SQRT: begin
                x_reg    <= x_next;
                root_reg <= root_next;
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    rms_reg <= root_next[SAMPLE_W-1:0];
                end
            end
            BK_MUL_A: prod_reg <= PROD_W'(level_reg) * d_eff;
            BK_MUL_B: prod_reg <= prod_reg + PROD_W'(rms_reg) * w_new;
            default:  step_reg <= step_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                level_reg   <= lv_clamped;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg.level          <= lv_clamped;
            m_data_reg.rms            <= rms_reg;
            m_data_reg.frames_counted <= div_reg;
            m_data_reg.overlong       <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/stereo_rms_level_meter_unit.sv
// Stereo RMS level meter. Frames (left/right Q1.15, last flag) are taken one per
// cycle; the front squares the mid value (l+r)>>1 and sums it, up to 4096 frames
// per buffer (later frames are dropped and flagged overlong). The last frame of a
// buffer hands the sum and count to a two-entry queue and the front goes on at
// full rate. The back turns each buffer into one result word: a bit-serial
// divide, a square root, multiply steps MUL_A and MUL_B for the smoothing
// level' = (level*decay + rms*(65536-decay))>>16 clamped to 32768, and a DONE
// step that loads the output register once free, then takes the next buffer.
// The frame input stalls only when both queue entries are still waiting. decay
// resets to 55706 and should be written only while the meter is idle.
module stereo_rms_level_meter_unit
    import srlm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  srlm_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output srlm_out_t          m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DECAY_W-1:0] cfg_data
);

    logic [DECAY_W-1:0] decay_reg;
    srlm_q_ctl_t        q_ctl;
    srlm_buf_t          push_buf;
    srlm_buf_t          head_buf;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= DECAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            decay_reg <= cfg_data;
        end
    end

    srlm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_ctl.full),
        .q_push  (q_ctl.push),
        .q_data  (push_buf)
    );

    srlm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_ctl.push),
        .wr_data (push_buf),
        .pop     (q_ctl.pop),
        .rd_data (head_buf),
        .full    (q_ctl.full),
        .empty   (q_ctl.empty)
    );

    srlm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_ctl.empty),
        .q_data  (head_buf),
        .q_pop   (q_ctl.pop),
        .decay   (decay_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ctl.push |-> !q_ctl.full)
        else $error("buffer word pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ctl.pop |-> !q_ctl.empty)
        else $error("buffer word popped from empty queue");

    a_level_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.level <= FULL_SCALE) && (m_data.rms <= FULL_SCALE))
        else $error("level or rms above full scale");

    a_frames_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.frames_counted != '0))
        else $error("result word with zero frames");

endmodule
